// ===== rtl/huff_pkg.sv =====
// Shared types and constants for the Huffman code builder.
package huff_pkg;

	localparam int SYM_W    = 8;
	localparam int LEAF_W   = 16;
	localparam int WEIGHT_W = 21;
	localparam int CODE_W   = 31;
	localparam int LEN_W    = 5;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_TAIL,
		S_MERGE_LO,
		S_MERGE_HI,
		S_WSTART,
		S_WCHK,
		S_WSTEP,
		S_EMIT
	} huff_state_t;

	typedef struct packed {
		logic load_leaf;
		logic clear_links;
		logic scan_init;
		logic scan_rd;
		logic merge_lo;
		logic merge_hi;
		logic walk_start;
		logic walk_rd;
		logic walk_step;
		logic emit;
		logic emit_last;
	} huff_cmd_t;

	typedef struct packed {
		logic at_root;
		logic out_free;
	} huff_status_t;

endpackage

// ===== rtl/huff_ctrl.sv =====
// Controller: load, merge scan sequencing and code walk sequencing.
module huff_ctrl #(
	parameter int MAX_LEAVES = 32,
	parameter int LW = 5,
	parameter int IW = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 leaf_last,
	input  huff_pkg::huff_status_t status,
	output huff_pkg::huff_cmd_t  cmd,
	output logic [LW-1:0]        leaf_idx,
	output logic [IW-1:0]        node_k,
	output logic [IW-1:0]        node_j,
	output logic [IW-1:0]        root
);
	import huff_pkg::*;

	huff_state_t state_q, state_nx;
	logic [LW-1:0] count_q, n_m1_q, i_q;
	logic [IW-1:0] k_q, j_q;
	logic          in_xfer, set_end;

	assign in_xfer  = in_valid && (state_q == S_IDLE);
	assign set_end  = leaf_last || (count_q == LW'(MAX_LEAVES - 1));
	assign root     = IW'({n_m1_q, 1'b0});
	assign node_k   = k_q;
	assign node_j   = j_q;
	assign leaf_idx = (state_q == S_IDLE) ? count_q : i_q;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer && set_end)
					state_nx = (count_q == '0) ? S_WSTART : S_SCAN;
			end
			S_SCAN:     if (j_q == k_q - IW'(1)) state_nx = S_TAIL;
			S_TAIL:     state_nx = S_MERGE_LO;
			S_MERGE_LO: state_nx = S_MERGE_HI;
			S_MERGE_HI: state_nx = (k_q == root) ? S_WSTART : S_SCAN;
			S_WSTART:   state_nx = S_WCHK;
			S_WCHK:     state_nx = status.at_root ? S_EMIT : S_WSTEP;
			S_WSTEP:    state_nx = S_WCHK;
			S_EMIT: begin
				if (status.out_free)
					state_nx = (i_q == n_m1_q) ? S_IDLE : S_WSTART;
			end
			default:    state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready        = 1'b1;
				cmd.load_leaf   = in_xfer;
				cmd.clear_links = in_xfer && set_end;
				cmd.scan_init   = in_xfer && set_end;
			end
			S_SCAN:     cmd.scan_rd = 1'b1;
			S_TAIL:     ;
			S_MERGE_LO: cmd.merge_lo = 1'b1;
			S_MERGE_HI: begin
				cmd.merge_hi  = 1'b1;
				cmd.scan_init = 1'b1;
			end
			S_WSTART:   cmd.walk_start = 1'b1;
			S_WCHK:     cmd.walk_rd = !status.at_root;
			S_WSTEP:    cmd.walk_step = 1'b1;
			S_EMIT: begin
				cmd.emit      = status.out_free;
				cmd.emit_last = (i_q == n_m1_q);
			end
			default:    ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			n_m1_q  <= '0;
			i_q     <= '0;
			k_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_nx;
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (set_end) begin
							n_m1_q  <= count_q;
							count_q <= '0;
							k_q     <= IW'(count_q) + IW'(1);
							j_q     <= '0;
							i_q     <= '0;
						end else begin
							count_q <= count_q + LW'(1);
						end
					end
				end
				S_SCAN: j_q <= j_q + IW'(1);
				S_MERGE_HI: begin
					k_q <= k_q + IW'(1);
					j_q <= '0;
				end
				S_EMIT: if (status.out_free) i_q <= i_q + LW'(1);
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/huff_dp.sv =====
// Datapath: node stores, two-smallest search, parent walk and result register.
module huff_dp #(
	parameter int MAX_LEAVES = 32,
	parameter int LW = 5,
	parameter int IW = 6
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  huff_pkg::huff_cmd_t            cmd,
	output huff_pkg::huff_status_t         status,
	input  logic [LW-1:0]                  leaf_idx,
	input  logic [IW-1:0]                  node_k,
	input  logic [IW-1:0]                  node_j,
	input  logic [IW-1:0]                  root,
	input  logic [huff_pkg::LEAF_W-1:0]    leaf_weight,
	input  logic [huff_pkg::SYM_W-1:0]     leaf_symbol,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [huff_pkg::SYM_W-1:0]     out_symbol,
	output logic [huff_pkg::CODE_W-1:0]    code_bits,
	output logic [huff_pkg::LEN_W-1:0]     code_length,
	output logic                           out_last
);
	import huff_pkg::*;

	localparam int NODE_SLOTS = 2 * MAX_LEAVES - 1;

	logic [WEIGHT_W-1:0] weight_mem [NODE_SLOTS];
	logic [IW:0]         parent_mem [NODE_SLOTS]; // {is_right, parent}
	logic [SYM_W-1:0]    sym_mem    [MAX_LEAVES];
	logic [NODE_SLOTS-1:0] linked_q;

	logic [WEIGHT_W-1:0] w_rd_s1;
	logic [IW-1:0]       j_s1;
	logic                scan_v_s1;
	logic [IW:0]         par_rd_q;
	logic [SYM_W-1:0]    sym_rd_q;

	logic                lo_v_q, hi_v_q;
	logic [WEIGHT_W-1:0] lo_w_q, hi_w_q;
	logic [IW-1:0]       lo_idx_q, hi_idx_q;

	logic [IW-1:0]       c_q;
	logic [LEN_W-1:0]    depth_q;
	logic [CODE_W-1:0]   code_q;
	logic                out_valid_q;

	logic [WEIGHT_W:0]   sum_full;
	logic [WEIGHT_W-1:0] sum_sat;
	logic                wr_en;
	logic [IW-1:0]       wr_addr;
	logic [WEIGHT_W-1:0] wr_data;
	logic                cand;
	logic [LEN_W-1:0]    shamt;

	assign sum_full = {1'b0, lo_w_q} + {1'b0, hi_w_q};
	assign sum_sat  = sum_full[WEIGHT_W] ? '1 : sum_full[WEIGHT_W-1:0];

	assign wr_en   = cmd.load_leaf || cmd.merge_lo;
	assign wr_addr = cmd.load_leaf ? IW'(leaf_idx) : node_k;
	assign wr_data = cmd.load_leaf ? WEIGHT_W'(leaf_weight) : sum_sat;

	always_ff @(posedge clk) begin
		if (wr_en)
			weight_mem[wr_addr] <= wr_data;
		if (cmd.scan_rd)
			w_rd_s1 <= weight_mem[node_j];
	end

	always_ff @(posedge clk) begin
		if (cmd.merge_lo)
			parent_mem[lo_idx_q] <= {1'b0, node_k};
		else if (cmd.merge_hi)
			parent_mem[hi_idx_q] <= {1'b1, node_k};
		if (cmd.walk_rd)
			par_rd_q <= parent_mem[c_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_leaf)
			sym_mem[leaf_idx] <= leaf_symbol;
		if (cmd.walk_start)
			sym_rd_q <= sym_mem[leaf_idx];
	end

	// scan compare; slots arrive in rising order, so equal weight keeps the older pick
	assign cand = scan_v_s1 && !linked_q[j_s1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			linked_q  <= '0;
			scan_v_s1 <= 1'b0;
			lo_v_q    <= 1'b0;
			hi_v_q    <= 1'b0;
		end else begin
			scan_v_s1 <= cmd.scan_rd;
			if (cmd.clear_links)
				linked_q <= '0;
			else if (cmd.merge_lo)
				linked_q[lo_idx_q] <= 1'b1;
			else if (cmd.merge_hi)
				linked_q[hi_idx_q] <= 1'b1;
			if (cmd.scan_init) begin
				lo_v_q <= 1'b0;
				hi_v_q <= 1'b0;
			end else if (cand) begin
				if (!lo_v_q || w_rd_s1 < lo_w_q) begin
					hi_v_q <= lo_v_q;
					lo_v_q <= 1'b1;
				end else if (!hi_v_q || w_rd_s1 < hi_w_q) begin
					hi_v_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cand) begin
			if (!lo_v_q || w_rd_s1 < lo_w_q) begin
				hi_w_q   <= lo_w_q;
				hi_idx_q <= lo_idx_q;
				lo_w_q   <= w_rd_s1;
				lo_idx_q <= j_s1;
			end else if (!hi_v_q || w_rd_s1 < hi_w_q) begin
				hi_w_q   <= w_rd_s1;
				hi_idx_q <= j_s1;
			end
		end
		if (cmd.scan_rd)
			j_s1 <= node_j;
	end

	// code bits enter at the top; past 31 levels only the root-most bits remain
	always_ff @(posedge clk) begin
		if (cmd.walk_start) begin
			c_q     <= IW'(leaf_idx);
			depth_q <= '0;
			code_q  <= '0;
		end else if (cmd.walk_step) begin
			c_q    <= par_rd_q[IW-1:0];
			code_q <= {par_rd_q[IW], code_q[CODE_W-1:1]};
			if (depth_q != LEN_W'(CODE_W))
				depth_q <= depth_q + LEN_W'(1);
		end
	end

	assign status.at_root  = (c_q == root);
	assign status.out_free = !out_valid_q || out_ready;
	assign shamt = LEN_W'(CODE_W) - depth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_symbol  <= sym_rd_q;
			code_bits   <= code_q >> shamt;
			code_length <= depth_q;
			out_last    <= cmd.emit_last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/huffman_code_builder_core.sv =====
// Top level of the Huffman code builder.
//  channel | direction | handshake            | payload
//  leaf    | in        | in_valid / in_ready   | leaf_weight, leaf_symbol, leaf_last
//  code    | out       | out_valid / out_ready | out_symbol, code_bits, code_length, out_last
// A leaf without the last flag is stored while idle. The set-ending leaf starts the build:
// merge k scans slots 0..k-1 through the weight memory at one slot per cycle, then passes
// S_TAIL, S_MERGE_LO (sum and low link) and S_MERGE_HI (high link); each code then walks
// from its leaf to the root, with a parent-memory read and a step per tree level.
// Reset empties the leaf set; node stores are not cleared. A stalled result holds the
// next code in the walk; new leaves are taken once the last code is in the result register.
module huffman_code_builder_core #(
	parameter int MAX_LEAVES = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [huff_pkg::LEAF_W-1:0]    leaf_weight,
	input  logic [huff_pkg::SYM_W-1:0]     leaf_symbol,
	input  logic                           leaf_last,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [huff_pkg::SYM_W-1:0]     out_symbol,
	output logic [huff_pkg::CODE_W-1:0]    code_bits,
	output logic [huff_pkg::LEN_W-1:0]     code_length,
	output logic                           out_last
);
	import huff_pkg::*;

	localparam int LW = $clog2(MAX_LEAVES);
	localparam int IW = $clog2(2 * MAX_LEAVES - 1);

	huff_cmd_t    cmd;
	huff_status_t status;
	logic [LW-1:0] leaf_idx;
	logic [IW-1:0] node_k, node_j, root;

	huff_ctrl #(.MAX_LEAVES(MAX_LEAVES), .LW(LW), .IW(IW)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.leaf_last(leaf_last),
		.status   (status),
		.cmd      (cmd),
		.leaf_idx (leaf_idx),
		.node_k   (node_k),
		.node_j   (node_j),
		.root     (root)
	);

	huff_dp #(.MAX_LEAVES(MAX_LEAVES), .LW(LW), .IW(IW)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.leaf_idx   (leaf_idx),
		.node_k     (node_k),
		.node_j     (node_j),
		.root       (root),
		.leaf_weight(leaf_weight),
		.leaf_symbol(leaf_symbol),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_symbol (out_symbol),
		.code_bits  (code_bits),
		.code_length(code_length),
		.out_last   (out_last)
	);

endmodule

// ===== rtl/huff_checker.sv =====
// Port-level checks for the Huffman code builder, bound to the top level.
module huff_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        leaf_last,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [huff_pkg::SYM_W-1:0]  out_symbol,
	input logic [huff_pkg::CODE_W-1:0] code_bits,
	input logic [huff_pkg::LEN_W-1:0]  code_length,
	input logic                        out_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_symbol) && $stable(code_bits)
			&& $stable(code_length) && $stable(out_last))
		else $error("result changed while stalled");

	a_code_fits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (code_bits >> code_length) == '0)
		else $error("code bits above code length");

	a_build_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && leaf_last |=> !in_ready)
		else $error("leaf taken right after set end");

	a_no_leaf_mid_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> !in_ready)
		else $error("leaf taken while codes still pending");

endmodule

bind huffman_code_builder_core huff_checker u_huff_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.leaf_last  (leaf_last),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.out_symbol (out_symbol),
	.code_bits  (code_bits),
	.code_length(code_length),
	.out_last   (out_last)
);
